### sv/mtw_pkg.sv
// Shared types, constants and word functions for the MT19937 word generator.
// No dependencies; every other file imports this package.
`default_nettype none

package mtw_pkg;

    localparam int STATE_LEN    = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int IDX_W        = 10;
    localparam int WORD_W       = 32;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [1:0]        t_kind;

    localparam t_kind KIND_DRAW   = 2'd0;
    localparam t_kind KIND_RESEED = 2'd1;
    localparam t_kind KIND_LOAD   = 2'd2;

    localparam t_idx IDX_LAST     = t_idx'(STATE_LEN - 1);
    localparam t_idx IDX_TWIST    = t_idx'(STATE_LEN);
    localparam t_idx IDX_UNSEEDED = t_idx'(STATE_LEN + 1);
    localparam t_idx IDX_FAR_WRAP = t_idx'(STATE_LEN - SHIFT_OFFSET);

    localparam t_word TWIST_MATRIX = 32'h9908b0df;
    localparam t_word TEMPER_B     = 32'h9d2c5680;
    localparam t_word TEMPER_C     = 32'hefc60000;
    localparam t_word LCG_MUL      = 32'd69069;
    localparam t_word DEFAULT_SEED = 32'd4357;

    // RAM write request
    typedef struct packed {
        logic  we;
        t_idx  addr;
        t_word wdata;
    } t_ram_wr;

    // seeder write stream plus end-of-sweep flag
    typedef struct packed {
        t_ram_wr wr;
        logic    done;
    } t_seed_wr;

    function automatic t_word lcg_next(input t_word s);
        t_word p;
        p = s * LCG_MUL;
        return p + 32'd1;
    endfunction

    function automatic t_idx nxt_idx(input t_idx i);
        return (i == IDX_LAST) ? '0 : i + t_idx'(1);
    endfunction

    function automatic t_idx far_idx(input t_idx i);
        return (i >= IDX_FAR_WRAP) ? i - IDX_FAR_WRAP : i + t_idx'(SHIFT_OFFSET);
    endfunction

    function automatic t_word twist_one(input t_word a, input t_word b, input t_word far);
        t_word y;
        t_word r;
        y = {a[31], b[30:0]};
        r = far ^ (y >> 1);
        if (y[0]) begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

    function automatic t_word temper(input t_word x);
        t_word y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

### sv/mtw_if.sv
// Valid/ready channel interfaces: command words in, tempered words out.
// Depends on mtw_pkg.
`default_nettype none

interface mtw_in_if import mtw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_idx  word_index;
    t_word word_value;

    modport source (output valid, output kind, output word_index, output word_value,
                    input ready);
    modport sink   (input valid, input kind, input word_index, input word_value,
                    output ready);
endinterface

interface mtw_out_if import mtw_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

### sv/mtw_state_ram.sv
// 624 x 32 state memory: port A read/write, port B read, registered reads.
// Depends on mtw_pkg.
`default_nettype none

module mtw_state_ram import mtw_pkg::*; (
    input  wire logic    i_clk,
    input  wire t_ram_wr i_a_wr,
    input  wire t_idx    i_a_addr,
    output t_word        o_a_rdata,
    input  wire t_idx    i_b_addr,
    output t_word        o_b_rdata
);

    t_word r_mem [STATE_LEN];

    always_ff @(posedge i_clk) begin
        if (i_a_wr.we) begin
            r_mem[i_a_wr.addr] <= i_a_wr.wdata;
        end
        o_a_rdata <= r_mem[i_a_addr];
    end

    always_ff @(posedge i_clk) begin
        o_b_rdata <= r_mem[i_b_addr];
    end

endmodule

`default_nettype wire

### sv/mtw_seeder.sv
// LCG seeding sweep: writes all 624 state words, two LCG steps per word.
// Depends on mtw_pkg.
`default_nettype none

module mtw_seeder import mtw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_word i_seed,
    output t_seed_wr   o_seed_wr
);

    logic  r_busy, n_busy;
    logic  r_phase, n_phase;
    t_idx  r_addr, n_addr;
    t_word r_s, n_s;
    logic [15:0] r_hi, n_hi;

    always_comb begin
        n_busy    = r_busy;
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_s       = r_s;
        n_hi      = r_hi;
        o_seed_wr = '0;
        if (i_start) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_addr  = '0;
            n_s     = i_seed;
        end else if (r_busy) begin
            n_s     = lcg_next(r_s);
            n_phase = ~r_phase;
            if (!r_phase) begin
                // upper half comes from the current LCG value
                n_hi = r_s[31:16];
            end else begin
                o_seed_wr.wr.we    = 1'b1;
                o_seed_wr.wr.addr  = r_addr;
                o_seed_wr.wr.wdata = {r_hi, r_s[31:16]};
                if (r_addr == IDX_LAST) begin
                    n_busy         = 1'b0;
                    o_seed_wr.done = 1'b1;
                end else begin
                    n_addr = r_addr + t_idx'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
        end
        r_addr <= n_addr;
        r_s    <= n_s;
        r_hi   <= n_hi;
    end

endmodule

`default_nettype wire

### sv/mt19937_word_generator_top.sv
// Top level of the MT19937 word generator: command FSM, lazy twist, output register.
// Depends on mtw_pkg, mtw_if, mtw_state_ram and mtw_seeder.
//
// Usage:
//   i_word (valid/ready) carries one command word: kind draw, reseed or load.
//   o_word (valid/ready) returns one tempered random_word per draw.
//   i_cfg_we/i_cfg_wdata write the seed register (reset 4357); write it while idle.
// Operation:
//   A draw reads the cur and far words, then the next word, then writes the
//   twisted word back and tempers it into the output register.
//   The twist runs one word per draw; i_word.ready is low until the draw is done.
//   A load while no pass is partly consumed is written as it is accepted. A load into
//   a partly consumed pass first twists the rest of that pass, with i_word.ready low,
//   then writes the word. A reseed runs the LCG sweep, ready low.
//   The first draw after reset seeds from the seed register first.
// Reset: i_rst_n synchronous, active low; the generator returns to unseeded.
//   The state RAM is not cleared.
// Stall: a finished word waits in the output register; the next command is
//   still taken, and a following draw holds before write-back until o_word
//   is free.
`default_nettype none

module mt19937_word_generator_top import mtw_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtw_in_if.sink     i_word,
    mtw_out_if.source  o_word,
    input  wire logic  i_cfg_we,
    input  wire t_word i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEED = 3'd1;  // LCG sweep in progress
    localparam logic [2:0] ST_RD0  = 3'd2;  // issue reads of cur and far
    localparam logic [2:0] ST_RD1  = 3'd3;  // issue read of next, latch cur/far
    localparam logic [2:0] ST_TW   = 3'd4;  // twist, write back, emit a draw's word
    localparam logic [2:0] ST_LD   = 3'd5;  // held load written after tail twist

    logic [2:0] r_state, n_state;
    t_idx       r_read_idx, n_read_idx;
    t_idx       r_cur, n_cur;
    logic       r_draw_pend, n_draw_pend;
    logic       r_fin, n_fin;
    t_idx       r_ld_idx, n_ld_idx;
    t_word      r_ld_val, n_ld_val;
    t_word      r_seed;
    t_word      r_a, n_a;
    t_word      r_far, n_far;
    logic       r_out_valid, n_out_valid;
    t_word      r_out_word, n_out_word;

    t_ram_wr    ram_wr;
    t_idx       ram_a_addr;
    t_idx       ram_b_addr;
    t_word      ram_a_rdata;
    t_word      ram_b_rdata;
    t_seed_wr   seed_wr;
    logic       seed_start;

    logic       in_acc;
    logic       out_free;
    logic       tw_fire;
    t_idx       idle_idx;
    t_word      tw_word;

    assign i_word.ready      = (r_state == ST_IDLE);
    assign in_acc            = i_word.valid && i_word.ready;
    assign o_word.valid      = r_out_valid;
    assign o_word.random_word = r_out_word;
    assign out_free          = !r_out_valid || o_word.ready;
    assign tw_fire           = (r_state == ST_TW) && out_free;
    // after a full pass (or seeding/load) the next draw twists from word 0
    assign idle_idx          = (r_read_idx >= IDX_TWIST) ? '0 : r_read_idx;
    // words below cur are already twisted in place, which matches a full twist
    assign tw_word           = twist_one(r_a, ram_a_rdata, r_far);

    always_comb begin
        n_state     = r_state;
        n_read_idx  = r_read_idx;
        n_cur       = r_cur;
        n_draw_pend = r_draw_pend;
        n_fin       = r_fin;
        n_ld_idx    = r_ld_idx;
        n_ld_val    = r_ld_val;
        n_a         = r_a;
        n_far       = r_far;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        seed_start  = 1'b0;
        ram_wr      = '0;
        ram_a_addr  = r_cur;
        ram_b_addr  = far_idx(r_cur);

        if (r_out_valid && o_word.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                ram_a_addr = idle_idx;
                ram_b_addr = far_idx(idle_idx);
                if (in_acc) begin
                    unique case (i_word.kind)
                        KIND_DRAW: begin
                            if (r_read_idx == IDX_UNSEEDED) begin
                                seed_start  = 1'b1;
                                n_draw_pend = 1'b1;
                                n_state     = ST_SEED;
                            end else begin
                                n_cur   = idle_idx;
                                n_state = ST_RD1;
                            end
                        end
                        KIND_RESEED: begin
                            seed_start  = 1'b1;
                            n_draw_pend = 1'b0;
                            n_state     = ST_SEED;
                        end
                        KIND_LOAD: begin
                            if (i_word.word_index < IDX_TWIST) begin
                                if (r_read_idx < IDX_TWIST) begin
                                    // pass partly consumed: twist its tail, then write
                                    n_ld_idx = i_word.word_index;
                                    n_ld_val = i_word.word_value;
                                    n_fin    = 1'b1;
                                    n_cur    = r_read_idx;
                                    n_state  = ST_RD0;
                                end else begin
                                    ram_wr.we    = 1'b1;
                                    ram_wr.addr  = i_word.word_index;
                                    ram_wr.wdata = i_word.word_value;
                                    ram_a_addr   = i_word.word_index;
                                    n_read_idx   = IDX_TWIST;
                                end
                            end
                        end
                        default: begin
                            // unused kind: accepted, no effect
                        end
                    endcase
                end
            end
            ST_SEED: begin
                ram_wr     = seed_wr.wr;
                ram_a_addr = seed_wr.wr.addr;
                if (seed_wr.done) begin
                    n_read_idx = IDX_TWIST;
                    n_cur      = '0;
                    n_state    = r_draw_pend ? ST_RD0 : ST_IDLE;
                end
            end
            ST_RD0: begin
                n_state = ST_RD1;
            end
            ST_RD1: begin
                ram_a_addr = nxt_idx(r_cur);
                n_a        = ram_a_rdata;
                n_far      = ram_b_rdata;
                n_state    = ST_TW;
            end
            ST_TW: begin
                // hold the next-word read while the output is blocked
                ram_a_addr = nxt_idx(r_cur);
                if (r_fin) begin
                    // tail twist: write back only, no word out
                    ram_wr.we    = 1'b1;
                    ram_wr.addr  = r_cur;
                    ram_wr.wdata = tw_word;
                    ram_a_addr   = r_cur;
                    if (r_cur == IDX_LAST) begin
                        n_state = ST_LD;
                    end else begin
                        n_cur   = nxt_idx(r_cur);
                        n_state = ST_RD0;
                    end
                end else if (tw_fire) begin
                    ram_wr.we    = 1'b1;
                    ram_wr.addr  = r_cur;
                    ram_wr.wdata = tw_word;
                    ram_a_addr   = r_cur;
                    n_out_valid  = 1'b1;
                    n_out_word   = temper(tw_word);
                    n_read_idx   = r_cur + t_idx'(1);
                    n_draw_pend  = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            ST_LD: begin
                ram_wr.we    = 1'b1;
                ram_wr.addr  = r_ld_idx;
                ram_wr.wdata = r_ld_val;
                ram_a_addr   = r_ld_idx;
                n_read_idx   = IDX_TWIST;
                n_fin        = 1'b0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_read_idx  <= IDX_UNSEEDED;
            r_draw_pend <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
            r_seed      <= DEFAULT_SEED;
        end else begin
            r_state     <= n_state;
            r_read_idx  <= n_read_idx;
            r_draw_pend <= n_draw_pend;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
        r_cur      <= n_cur;
        r_ld_idx   <= n_ld_idx;
        r_ld_val   <= n_ld_val;
        r_a        <= n_a;
        r_far      <= n_far;
        r_out_word <= n_out_word;
    end

    mtw_state_ram u_ram (
        .i_clk     (i_clk),
        .i_a_wr    (ram_wr),
        .i_a_addr  (ram_a_addr),
        .o_a_rdata (ram_a_rdata),
        .i_b_addr  (ram_b_addr),
        .o_b_rdata (ram_b_rdata)
    );

    mtw_seeder u_seeder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (seed_start),
        .i_seed    (r_seed),
        .o_seed_wr (seed_wr)
    );

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_idx <= IDX_UNSEEDED)
        else $error("read index out of range");

    a_seed_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seed_wr.wr.we |-> r_state == ST_SEED)
        else $error("seeder write outside sweep");

    a_out_from_twist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_TW)
        else $error("output word not produced by twist step");

    a_draw_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_word.kind == KIND_DRAW && r_read_idx != IDX_UNSEEDED
        |=> r_state == ST_RD1)
        else $error("draw did not start reads");

    a_seeded_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEED && seed_wr.done |=> r_read_idx == IDX_TWIST)
        else $error("index not set after seeding");
`endif

endmodule

`default_nettype wire

### tb/tb_mt19937_word_generator_top.sv
// Self-checking testbench for mt19937_word_generator_top: directed command table, then
// random phases over several seeds, each word checked against an in-bench MT19937 model.
// Depends on mtw_pkg, mtw_if and the generator RTL.

module tb_mt19937_word_generator_top;
    import mtw_pkg::*;

    localparam t_kind KIND_NONE    = 2'd3;        // unused kind, must be a no-op
    localparam int    DIR_N        = 22;
    localparam int    RANDOM_ITEMS = 1400;
    localparam int    LONG_RUN     = 650;         // crosses the 624-word wrap without a load
    localparam int    RUN_LIMIT    = 100_000_000; // several times the slowest run

    // one directed command; fixed marks a word we can state without the model
    typedef struct packed {
        t_kind kind;
        t_idx  idx;
        t_word val;
        logic  fixed;
        t_word word;
    } t_dir_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  cfg_we;
    t_word cfg_wdata;

    mtw_in_if  cmd_if ();
    mtw_out_if rnd_if ();

    mt19937_word_generator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (cmd_if),
        .o_word      (rnd_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Generator model: state words, read position, seed register
    // ---------------------------------------------------------------------
    t_word gen_words [STATE_LEN];
    t_idx  gen_pos;
    t_word gen_seed;

    t_word    pending_words [$];   // tempered words still owed by the block
    int       mismatch_count = 0;
    int       items_sent = 0;
    int       send_quiet = 0;
    int       recv_quiet = 0;
    t_dir_row dir_rows [DIR_N];

    // legacy 69069 seeding: two LCG steps per word, upper halves packed together
    function automatic void fill_from_seed(t_word s);
        t_word hi;
        for (int n = 0; n < STATE_LEN; n++) begin
            hi = s & 32'hffff0000;
            s = s * LCG_MUL + 32'd1;
            gen_words[n] = hi | (s >> 16);
            s = s * LCG_MUL + 32'd1;
        end
        gen_pos = IDX_TWIST;
    endfunction

    // in-place twist; words past the far wrap see already-updated neighbors
    function automatic void twist_all();
        t_word mixed;
        for (int k = 0; k < STATE_LEN; k++) begin
            mixed = {gen_words[k][31], gen_words[(k + 1) % STATE_LEN][30:0]};
            gen_words[k] = gen_words[(k + SHIFT_OFFSET) % STATE_LEN] ^ (mixed >> 1)
                         ^ (mixed[0] ? TWIST_MATRIX : 32'h0);
        end
    endfunction

    function automatic t_word tempered(t_word x);
        t_word y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    // applies one accepted command; returns 1 and the word when a draw
    function automatic bit advance_twister(input t_kind k, input t_idx i, input t_word v,
                                           output t_word w);
        w = '0;
        case (k)
            KIND_DRAW: begin
                if (gen_pos >= IDX_TWIST) begin
                    if (gen_pos == IDX_UNSEEDED) fill_from_seed(gen_seed);
                    twist_all();
                    gen_pos = '0;
                end
                w = tempered(gen_words[gen_pos]);
                gen_pos = gen_pos + t_idx'(1);
                return 1'b1;
            end
            KIND_RESEED: fill_from_seed(gen_seed);
            KIND_LOAD: begin
                // out-of-range loads leave state and position alone
                if (i < STATE_LEN) begin
                    gen_words[i] = v;
                    gen_pos = IDX_TWIST;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // idle length per word, with occasional stretches of back-to-back traffic
    function automatic int pick_pause(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------------
    // Drives one command word and holds it until accepted. valid is only
    // lowered when a gap is drawn, so back-to-back words never glitch it.
    task automatic push_item(t_kind k, t_idx i, t_word v, logic fixed, t_word fixed_word);
        int    gap;
        t_word w;
        gap = pick_pause(send_quiet);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.kind       <= k;
        cmd_if.word_index <= i;
        cmd_if.word_value <= v;
        do @(posedge i_clk); while (!cmd_if.ready);
        items_sent++;
        if (advance_twister(k, i, v, w)) pending_words.push_back(fixed ? fixed_word : w);
    endtask

    task automatic push_draws(int n);
        repeat (n) push_item(KIND_DRAW, t_idx'($urandom_range(0, 1023)), $urandom(), 1'b0, '0);
    endtask

    task automatic push_load(int idx, t_word v);
        push_item(KIND_LOAD, t_idx'(idx), v, 1'b0, '0);
    endtask

    // Drain all owed words, then wait until the block takes commands again,
    // since a reseed or load as the last command leaves no word to wait for.
    task automatic settle_block();
        cmd_if.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    task automatic write_seed(t_word s);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        gen_seed = s;
    endtask

    // One random stretch of commands. Mostly draws; loads come as short runs
    // followed by draws so the twist actually consumes them.
    task automatic run_segment();
        int   r;
        int   n;
        int   k;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            push_draws($urandom_range(1, 30));
        end else if (r < 58) begin
            push_item(KIND_RESEED, t_idx'($urandom_range(0, 1023)), $urandom(), 1'b0, '0);
            push_draws($urandom_range(1, 8));
        end else if (r < 72) begin
            n = $urandom_range(1, 6);
            repeat (n) push_load($urandom_range(0, STATE_LEN - 1), pick_word());
            push_draws($urandom_range(1, 12));
        end else if (r < 82) begin
            // the three words that feed one twisted word
            k = $urandom_range(0, STATE_LEN - 1);
            push_load(k, pick_word());
            push_load((k + 1) % STATE_LEN, pick_word());
            push_load((k + SHIFT_OFFSET) % STATE_LEN, pick_word());
            push_draws($urandom_range(1, 4));
        end else if (r < 90) begin
            push_load($urandom_range(STATE_LEN, 1023), $urandom());
            push_draws($urandom_range(1, 3));
        end else if (r < 95) begin
            push_item(KIND_NONE, t_idx'($urandom_range(0, 1023)), $urandom(), 1'b0, '0);
            push_draws(1);
        end else begin
            push_load($urandom_range(0, 1) ? STATE_LEN - 1 : 0, pick_word());
            push_draws($urandom_range(1, 6));
        end
    endtask

    initial begin
        t_word seed;
        int    phase_end;

        cmd_if.valid      <= 1'b0;
        cmd_if.kind       <= KIND_DRAW;
        cmd_if.word_index <= '0;
        cmd_if.word_value <= '0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        i_rst_n           <= 1'b0;

        gen_seed = DEFAULT_SEED;
        gen_pos  = IDX_UNSEEDED;
        foreach (gen_words[n]) gen_words[n] = '0;

        // Directed commands. The block starts unseeded: no-ops and out-of-range
        // loads must keep it so, and the first draw seeds from the reset seed.
        // Zeroing words 0, 1 and 397 makes the next twisted word 0 -> draws 0.
        dir_rows = '{
            '{KIND_NONE,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd1023, 32'hffffffff, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd624,  32'ha5a5a5a5, 1'b0, 32'h0},
            '{KIND_NONE,   10'd1023, 32'hffffffff, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd1023, 32'hffffffff, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_RESEED, 10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd1,    32'h00000000, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd397,  32'h00000000, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b1, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd623,  32'hffffffff, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd0,    32'hffffffff, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd1,    32'h7fffffff, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_LOAD,   10'd1000, 32'h00000000, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0},
            '{KIND_RESEED, 10'd1023, 32'hffffffff, 1'b0, 32'h0},
            '{KIND_DRAW,   10'd0,    32'h00000000, 1'b0, 32'h0}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            push_item(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].val,
                      dir_rows[r].fixed, dir_rows[r].word);

        // Random phases: zero, all-ones, default, then random and single-bit seeds.
        // A few phases skip the opening reseed so the old state carries over.
        for (int phase = 0; items_sent < DIR_N + RANDOM_ITEMS; phase++) begin
            case (phase)
                0: seed = 32'h00000000;
                1: seed = 32'hffffffff;
                2: seed = DEFAULT_SEED;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       seed = 32'h1 << $urandom_range(0, 31);
                        1:       seed = ~(32'h1 << $urandom_range(0, 31));
                        default: seed = $urandom();
                    endcase
                end
            endcase
            settle_block();
            write_seed(seed);
            if (phase < 3 || $urandom_range(0, 9) != 0)
                push_item(KIND_RESEED, t_idx'($urandom_range(0, 1023)), $urandom(), 1'b0, '0);
            if (phase == 1) push_draws(LONG_RUN);
            phase_end = items_sent + $urandom_range(80, 160);
            while (items_sent < phase_end && items_sent < DIR_N + RANDOM_ITEMS)
                run_segment();
        end

        settle_block();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Word side: random back-pressure, every handshake checked in order
    // ---------------------------------------------------------------------
    initial begin
        int    stall;
        t_word want;
        rnd_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = pick_pause(recv_quiet);
            if (stall != 0) begin
                rnd_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rnd_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rnd_if.valid);
            if (pending_words.size() == 0) begin
                note_mismatch($sformatf("word %h with no draw pending", rnd_if.random_word));
            end else begin
                want = pending_words.pop_front();
                if (rnd_if.random_word !== want)
                    note_mismatch($sformatf("random_word got %h want %h",
                                            rnd_if.random_word, want));
            end
        end
    end

    // hang guard
    initial begin
        #RUN_LIMIT;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
